[src/bfdh_pkg.sv]
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared constants and controller/datapath interface types for the Bloom
// filter double-hash unit.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  localparam int MAX_BITS   = 65536;
  localparam int MAX_HASHES = 16;

  // Fixed field widths
  localparam int HASH_W = 16;
  localparam int FB_W   = 17;
  localparam int NH_W   = 5;
  localparam int CFG_W  = 17;
  localparam int CFG_IDX_W = 1;

  // Derived widths
  localparam int POS_W  = $clog2(MAX_BITS);
  localparam int M_W    = POS_W + 1;
  localparam int K_W    = $clog2(MAX_HASHES + 1);
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROWS   = MAX_BITS / WORD_W;
  localparam int ROW_W  = POS_W - BIT_W;
  localparam int MODC_W = $clog2(HASH_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES  = 1'b1;

  localparam logic [FB_W-1:0] FB_RESET = 17'd65536;
  localparam logic [NH_W-1:0] NH_RESET = 5'd13;

  // Request command codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic clr;       // write one zero row of the clearing pass
    logic load;      // capture a new request
    logic mod_step;  // one restoring-remainder step
    logic rd;        // issue the store read for the current probe
    logic probe;     // test or set the current probe, then advance
  } bfdh_ctl_t;

  typedef struct packed {
    logic clr_last;
    logic need_mod;
    logic zero_probes;
    logic mod_last;
    logic is_add;
    logic bit_set;
    logic last_probe;
    logic result;
  } bfdh_sts_t;

endpackage

[src/bloom_filter_double_hash_unit.sv]
// Sequencing: each probe takes a store read and then a check; a hash that is
//   not below the modulus first goes through the bit-serial remainder unit, and
//   a query stops at the first clear cell. A new request is taken only once
//   the result of the last one has been handed to the output register.
// Reset: a clearing pass writes the 2048 store rows, one a cycle, before the
//   first request is taken; configuration writes are taken during it.
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_unit
// Bloom filter membership engine with double-hash probing over a 64K-bit
// store: configuration registers, controller, datapath and output register.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_unit
  import bfdh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [HASH_W-1:0]    hash_a,
  input  logic [HASH_W-1:0]    hash_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 possibly_present
);

  logic [FB_W-1:0] filter_bits;
  logic [NH_W-1:0] num_hashes;
  logic [M_W-1:0]  m_eff;
  logic [K_W-1:0]  k_eff;
  logic            out_free;
  logic            emit;
  bfdh_ctl_t       ctl;
  bfdh_sts_t       sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bits <= FB_RESET;
      num_hashes  <= NH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_BITS: filter_bits <= cfg_data[FB_W-1:0];
        REG_NUM_HASHES:  num_hashes  <= cfg_data[NH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp modulus to 1..MAX_BITS and probes to MAX_HASHES
  always_comb begin
    if (filter_bits == '0) begin
      m_eff = M_W'(1);
    end else if (M_W'(filter_bits) > M_W'(MAX_BITS)) begin
      m_eff = M_W'(MAX_BITS);
    end else begin
      m_eff = M_W'(filter_bits);
    end
    if (K_W'(num_hashes) > K_W'(MAX_HASHES)) begin
      k_eff = K_W'(MAX_HASHES);
    end else begin
      k_eff = K_W'(num_hashes);
    end
  end

  assign out_free = !out_valid || !out_stall;

  bfdh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .emit     (emit),
    .ctl      (ctl),
    .sts      (sts)
  );

  bfdh_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sts    (sts),
    .op     (cmd),
    .hash_a (hash_a),
    .hash_b (hash_b),
    .m_eff  (m_eff),
    .k_eff  (k_eff)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      possibly_present <= sts.result;
    end
  end

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit))
    else $error("result appeared without hand-off");

endmodule

[src/bfdh_ctrl.sv]
// ----------------------------------------------------------------------------
// bfdh_ctrl
// Sequencer: clearing pass, request capture, hash reduction, probe loop and
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module bfdh_ctrl
  import bfdh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      out_free,
  output logic      emit,
  output bfdh_ctl_t ctl,
  input  bfdh_sts_t sts
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next   = state;
    ctl          = '0;
    emit         = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ctl.load = 1'b1;
          if (sts.need_mod) begin
            state_next = S_MOD;
          end else if (sts.zero_probes) begin
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_MOD: begin
        ctl.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = sts.zero_probes ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        ctl.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        ctl.probe = 1'b1;
        // a clear cell ends a query early
        if ((!sts.is_add && !sts.bit_set) || sts.last_probe) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("request accepted but controller stayed idle");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result handed over while output register busy");

endmodule

[src/bfdh_dp.sv]
// ----------------------------------------------------------------------------
// bfdh_dp
// Datapath: bit store (32-bit rows), remainder unit for the hashes,
// probe position walk and hit tracking.
// ----------------------------------------------------------------------------
module bfdh_dp
  import bfdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  bfdh_ctl_t         ctl,
  output bfdh_sts_t         sts,
  input  logic              op,
  input  logic [HASH_W-1:0] hash_a,
  input  logic [HASH_W-1:0] hash_b,
  input  logic [M_W-1:0]    m_eff,
  input  logic [K_W-1:0]    k_eff
);

  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rdata;

  logic [ROW_W-1:0]  clr_row;
  logic [M_W-1:0]    m_q;
  logic [K_W-1:0]    k_q;
  logic              is_add;
  logic              hit;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  stride;
  logic [HASH_W-1:0] sh_a;
  logic [HASH_W-1:0] sh_b;
  logic [MODC_W-1:0] mod_cnt;
  logic [K_W-1:0]    n;

  logic              mem_we;
  logic [ROW_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] bit_mask;
  logic [M_W-1:0]    pos_sum;
  logic [POS_W-1:0]  pos_next;

  // one restoring step: value below twice the modulus
  function automatic logic [POS_W-1:0] reduce(input logic [M_W-1:0] t,
                                              input logic [M_W-1:0] m);
    logic [M_W-1:0] d;
    d = (t >= m) ? (t - m) : t;
    return d[POS_W-1:0];
  endfunction

  assign bit_mask  = WORD_W'(1) << pos[BIT_W-1:0];
  assign mem_we    = ctl.clr || (ctl.probe && is_add);
  assign mem_waddr = ctl.clr ? clr_row : pos[POS_W-1:BIT_W];
  assign mem_wdata = ctl.clr ? '0 : (rdata | bit_mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[pos[POS_W-1:BIT_W]];
    end
  end

  assign pos_sum  = {1'b0, pos} + {1'b0, stride};
  assign pos_next = reduce(pos_sum, m_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (ctl.clr) begin
      clr_row <= clr_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      m_q     <= m_eff;
      k_q     <= k_eff;
      is_add  <= (op == OP_ADD);
      hit     <= 1'b1;
      n       <= '0;
      mod_cnt <= '0;
      sh_a    <= hash_a;
      sh_b    <= hash_b;
      if (sts.need_mod) begin
        pos    <= '0;
        stride <= '0;
      end else begin
        pos    <= hash_a;
        stride <= hash_b;
      end
    end else if (ctl.mod_step) begin
      pos     <= reduce({pos, sh_a[HASH_W-1]}, m_q);
      stride  <= reduce({stride, sh_b[HASH_W-1]}, m_q);
      sh_a    <= sh_a << 1;
      sh_b    <= sh_b << 1;
      mod_cnt <= mod_cnt + 1'b1;
    end else if (ctl.probe) begin
      if (!is_add && !sts.bit_set) begin
        hit <= 1'b0;
      end
      pos <= pos_next;
      n   <= n + 1'b1;
    end
  end

  // probe count is latched at load; the zero-probe test reads the live setting
  always_comb begin
    sts.clr_last    = (clr_row == ROW_W'(ROWS - 1));
    sts.need_mod    = ({1'b0, hash_a} >= m_eff) || ({1'b0, hash_b} >= m_eff);
    sts.zero_probes = (k_eff == '0);
    sts.mod_last    = (mod_cnt == MODC_W'(HASH_W - 1));
    sts.is_add      = is_add;
    sts.bit_set     = rdata[pos[BIT_W-1:0]];
    sts.last_probe  = (n == (k_q - 1'b1));
    sts.result      = !is_add && hit;
  end

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.rd |-> ({1'b0, pos} < m_q))
    else $error("probe position beyond modulus");

  a_probe_count: assert property (@(posedge clk) disable iff (rst)
    ctl.probe |-> (n < k_q))
    else $error("more probes than configured");

endmodule

[test/tb_bloom_filter_double_hash_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_double_hash_unit
// Drives add and query requests into the Bloom filter unit under randomised
// gaps and back-pressure. A shadow bit store predicts each answer; results are
// compared in order. Register settings cover the modulus and probe-count
// extremes, including saturation and the zero cases.
// ----------------------------------------------------------------------------
module tb_bloom_filter_double_hash_unit;
  import bfdh_pkg::*;

  typedef struct {
    logic              op;
    logic [HASH_W-1:0] base;
    logic [HASH_W-1:0] stride;
    logic              present;
  } answer_t;

  typedef struct {
    logic [HASH_W-1:0] base;
    logic [HASH_W-1:0] stride;
  } key_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 cmd;
  logic [HASH_W-1:0]    hash_a;
  logic [HASH_W-1:0]    hash_b;
  logic                 out_valid;
  logic                 out_stall;
  logic                 possibly_present;

  // Shadow state of the block
  bit                filter_cells [MAX_BITS];
  logic [FB_W-1:0]   cur_filter_bits = FB_RESET;
  logic [NH_W-1:0]   cur_num_hashes  = NH_RESET;

  answer_t pending_answers [$];
  key_t    stored_keys [$];

  int  error_count    = 0;
  int  add_count      = 0;
  int  query_count    = 0;
  int  hit_count      = 0;
  int  setting_count  = 1;
  bit  send_steady    = 1'b0;
  bit  sink_steady    = 1'b0;

  bloom_filter_double_hash_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .hash_a           (hash_a),
    .hash_b           (hash_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .possibly_present (possibly_present)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** bloom_filter_double_hash_unit: FAILED **");
    $finish;
  end

  // Probe the shadow store; an add sets the probed cells and answers 0.
  function automatic logic probe_filter(input logic op, input logic [HASH_W-1:0] base,
                                        input logic [HASH_W-1:0] stride);
    longint unsigned modulus;
    longint unsigned probes;
    longint unsigned pos;
    longint unsigned n;
    logic            hit;
    modulus = (cur_filter_bits == '0) ? 64'd1 : 64'(cur_filter_bits);
    if (modulus > 64'(MAX_BITS)) modulus = 64'(MAX_BITS);
    probes = (cur_num_hashes > NH_W'(MAX_HASHES)) ? 64'(MAX_HASHES) : 64'(cur_num_hashes);
    hit = 1'b1;
    for (n = 0; n < probes && hit; n++) begin
      pos = (64'(base) + n * 64'(stride)) % modulus;
      if (op == OP_ADD) begin
        filter_cells[pos[POS_W-1:0]] = 1'b1;
      end else if (!filter_cells[pos[POS_W-1:0]]) begin
        hit = 1'b0;
      end
    end
    return (op == OP_ADD) ? 1'b0 : hit;
  endfunction

  function automatic logic [HASH_W-1:0] draw_hash();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return HASH_W'($urandom_range(0, 63));
      end
      default: begin
        return HASH_W'($urandom);
      end
    endcase
  endfunction

  task automatic send_request(input logic op, input logic [HASH_W-1:0] base,
                              input logic [HASH_W-1:0] stride);
    int      gap;
    answer_t ans;
    gap = send_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    hash_a   <= base;
    hash_b   <= stride;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    ans.op      = op;
    ans.base    = base;
    ans.stride  = stride;
    ans.present = probe_filter(op, base, stride);
    pending_answers.push_back(ans);
    if (op == OP_ADD) begin
      add_count++;
    end else begin
      query_count++;
      if (ans.present) hit_count++;
    end
  endtask

  // Hold off until every request has been answered.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [FB_W-1:0] fb, input logic [NH_W-1:0] nh);
    logic [CFG_W-1:0] noise;
    noise = CFG_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FILTER_BITS;
    cfg_data  <= fb;
    @(posedge clk);
    // upper bits of the probe-count write are don't-care
    cfg_index <= REG_NUM_HASHES;
    cfg_data  <= {noise[CFG_W-1:NH_W], nh};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_filter_bits = fb;
    cur_num_hashes  = nh;
    setting_count++;
  endtask

  task automatic test_reset_setting();
    send_request(OP_QUERY, 16'h0000, 16'h0000);
    send_request(OP_ADD,   16'h8000, 16'h7FFF);
    send_request(OP_QUERY, 16'h8000, 16'h7FFF);
    send_request(OP_QUERY, 16'h8000, 16'h8000);
    wait_idle();
  endtask

  task automatic test_zero_modulus();
    configure(17'd0, 5'd16);
    send_request(OP_QUERY, 16'h0005, 16'h0007);
    send_request(OP_ADD,   16'h0009, 16'h0003);
    send_request(OP_QUERY, 16'hFFFF, 16'hFFFF);
    wait_idle();
  endtask

  task automatic test_probe_saturation();
    configure(17'd1, 5'd31);
    send_request(OP_QUERY, 16'h1234, 16'h4321);
    send_request(OP_ADD,   16'hFFFF, 16'h0000);
    wait_idle();
  endtask

  task automatic test_oversized_modulus();
    configure(17'h1FFFF, 5'd16);
    send_request(OP_QUERY, 16'hFFFF, 16'hFFFF);
    send_request(OP_ADD,   16'hFFFF, 16'hFFFF);
    send_request(OP_QUERY, 16'hFFFF, 16'hFFFF);
    send_request(OP_ADD,   16'h0000, 16'hFFFF);
    send_request(OP_QUERY, 16'h0000, 16'hFFFF);
    send_request(OP_QUERY, 16'h0001, 16'h0001);
    wait_idle();
  endtask

  task automatic test_zero_probes();
    configure(17'd65536, 5'd0);
    send_request(OP_QUERY, 16'hABCD, 16'h1357);
    send_request(OP_ADD,   16'h2468, 16'h1111);
    wait_idle();
    // the add above must have left the store untouched
    configure(17'd65536, 5'd4);
    send_request(OP_QUERY, 16'h2468, 16'h1111);
    wait_idle();
  endtask

  task automatic test_modulus_change();
    configure(17'd4096, 5'd8);
    send_request(OP_ADD, 16'd5000, 16'd3);
    wait_idle();
    configure(17'd65536, 5'd8);
    send_request(OP_QUERY, 16'd5000, 16'd3);
    wait_idle();
    configure(17'd4096, 5'd8);
    send_request(OP_QUERY, 16'd5000, 16'd3);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [FB_W-1:0] fb_list [11];
    logic [NH_W-1:0] nh_list [11];
    key_t            key;
    int              choice;
    fb_list = '{FB_RESET, 17'd97, 17'd1024, 17'h1FFFF, 17'd2, 17'd4093,
                17'd65536, 17'd0, 17'd300, 17'd0, 17'd0};
    nh_list = '{NH_RESET, 5'd3, 5'd16, 5'd7, 5'd1, 5'd31,
                5'd1, 5'd9, 5'd0, 5'd0, 5'd0};
    // last two settings are drawn at random
    fb_list[9]  = FB_W'($urandom_range(0, 17'h1FFFF));
    nh_list[9]  = NH_W'($urandom_range(0, 31));
    fb_list[10] = FB_W'($urandom_range(1, 2048));
    nh_list[10] = NH_W'($urandom_range(1, 16));
    foreach (fb_list[p]) begin
      configure(fb_list[p], nh_list[p]);
      for (int i = 0; i < 59; i++) begin
        if (i % 20 == 0) begin
          send_steady = ($urandom_range(0, 3) == 0);
          sink_steady = ($urandom_range(0, 3) == 0);
        end
        choice = $urandom_range(0, 99);
        if (choice < 35 || stored_keys.size() == 0) begin
          key.base   = draw_hash();
          key.stride = draw_hash();
          stored_keys.push_back(key);
          send_request(OP_ADD, key.base, key.stride);
        end else if (choice < 75) begin
          key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          send_request(OP_QUERY, key.base, key.stride);
        end else if (choice < 85) begin
          // near miss: flip one bit of a stored key
          key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          key.base[$urandom_range(0, HASH_W - 1)] ^= 1'b1;
          send_request(OP_QUERY, key.base, key.stride);
        end else begin
          send_request(OP_QUERY, draw_hash(), draw_hash());
        end
      end
      wait_idle();
    end
    send_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Result side: random back-pressure, in-order comparison
  initial begin
    int      hold;
    answer_t ans;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      hold = sink_steady ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, possibly_present=%0b", $time, possibly_present);
        error_count++;
      end else begin
        ans = pending_answers.pop_front();
        if (possibly_present !== ans.present) begin
          $display("%0t: %s a=%04h b=%04h possibly_present expected %0b got %0b", $time,
                   (ans.op == OP_ADD) ? "add" : "query", ans.base, ans.stride,
                   ans.present, possibly_present);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_FILTER_BITS;
    cfg_data  = '0;
    in_valid  = 1'b0;
    cmd       = OP_ADD;
    hash_a    = '0;
    hash_b    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_setting();
    test_zero_modulus();
    test_probe_saturation();
    test_oversized_modulus();
    test_zero_probes();
    test_modulus_change();
    test_random_traffic();

    wait_idle();
    repeat (300) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_answers.size());
      error_count++;
    end
    $display("Ran %0d adds and %0d queries over %0d register settings;", add_count,
             query_count, setting_count);
    $display("%0d queries answered possibly-present, %0d mismatches.", hit_count, error_count);
    if (error_count == 0) begin
      $display("** bloom_filter_double_hash_unit: PASSED **");
    end else begin
      $display("** bloom_filter_double_hash_unit: FAILED **");
    end
    $finish;
  end

endmodule
